// ===== src/mbrot_pkg.sv =====
// Shared types, constants and helpers for the Mandelbrot escape-time pixel core.
package mbrot_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W      = 12;
    localparam int COORD_W    = 32;
    localparam int STEP_W     = 31;
    localparam int ITER_W     = 16;
    localparam int COLOR_W    = 24;
    localparam int CHAN_W     = 8;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int MUL_LANES  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int CPROD_W    = PIX_W + STEP_W;
    localparam int CSUM_W     = CPROD_W + 2;

    localparam int DIV_STEPS  = CHAN_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int DIV_NUM_W  = CHAN_W + ITER_W;
    localparam int DIV_SH_W   = ITER_W + DIV_STEPS - 1;

    localparam logic [PIX_W-1:0] PIX_X_MASK = PIX_W'(MAX_WIDTH - 1);
    localparam logic [PIX_W-1:0] PIX_Y_MASK = PIX_W'(MAX_HEIGHT - 1);

    localparam int ESC_SHIFT = 2 * FRAC_BITS + 2;
    localparam logic [PROD_W-1:0] ESC_LIMIT =
        (ESC_SHIFT > PROD_W - 1) ? {PROD_W{1'b1}} : (PROD_W'(1) << ESC_SHIFT);

    localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(64'sd2147483647);
    localparam logic signed [PROD_W-1:0] SAT_MIN = -PROD_W'(64'sd2147483648);

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_EDGE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_EDGE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_LOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_HIGH = 3'd6;

    typedef logic signed [COORD_W-1:0] t_mul_op;
    typedef logic signed [PROD_W-1:0]  t_mul_prod;
    typedef logic [DIV_NUM_W-1:0]      t_div_num;
    typedef logic [CHAN_W-1:0]         t_chan;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } t_pixel_in;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [ITER_W-1:0] iterations;
        logic              inside_set;
    } t_pixel_out;

    typedef struct packed {
        logic              start;
        logic [ITER_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_rsp;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[COORD_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[COORD_W-1:0];
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== src/mbrot_mul_unit.sv =====
// Three-lane signed 32x32 multiplier with registered products.
module mbrot_mul_unit
    import mbrot_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_en,
    input  t_mul_op   i_a [MUL_LANES],
    input  t_mul_op   i_b [MUL_LANES],
    output t_mul_prod o_p [MUL_LANES]
);

    t_mul_prod r_p [MUL_LANES];
    t_mul_prod n_p [MUL_LANES];

    always_comb begin
        for (int k = 0; k < MUL_LANES; k++) begin
            n_p[k] = PROD_W'(i_a[k]) * PROD_W'(i_b[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

// ===== src/mbrot_div_unit.sv =====
// Three-lane restoring divider producing an 8-bit quotient, one bit per cycle.
module mbrot_div_unit
    import mbrot_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    input  t_div_num i_num [MUL_LANES],
    output t_div_rsp o_rsp,
    output t_chan    o_quot [MUL_LANES]
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_SH_W-1:0]  r_dsh;
    t_div_num             r_rem  [MUL_LANES];
    t_chan                r_quot [MUL_LANES];

    logic                 ge     [MUL_LANES];

    always_comb begin
        for (int k = 0; k < MUL_LANES; k++) begin
            ge[k] = r_rem[k] >= DIV_NUM_W'(r_dsh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dsh <= {i_req.den, {(DIV_STEPS-1){1'b0}}};
            for (int k = 0; k < MUL_LANES; k++) begin
                r_rem[k]  <= i_num[k];
                r_quot[k] <= '0;
            end
        end else if (r_busy) begin
            r_dsh <= r_dsh >> 1;
            for (int k = 0; k < MUL_LANES; k++) begin
                if (ge[k]) begin
                    r_rem[k] <= r_rem[k] - DIV_NUM_W'(r_dsh);
                end
                r_quot[k] <= {r_quot[k][CHAN_W-2:0], ge[k]};
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_quot     = r_quot;

endmodule

// ===== src/mandelbrot_escape_time_pixel_core.sv =====
// Mandelbrot escape-time pixel core: sequencer, configuration registers and output stage.
// Path: input accept, c add, then multiply and update per iteration; inside points then go straight
//   to the output state, escaped points first pass colour multiply, divider load and divide.
// Throughput: one pixel at a time; each iteration steps through a multiply state and an update state,
//   using the shared three-lane multiplier, which also forms c and the colour products.
// Reset: synchronous active low; restores the default view, limit 50 and colour ramp.
module mandelbrot_escape_time_pixel_core
    import mbrot_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_pixel_in             i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_pixel_out            o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_CADD = 8'b0000_0010,
        S_ZMUL = 8'b0000_0100,
        S_ZUPD = 8'b0000_1000,
        S_RMUL = 8'b0001_0000,
        S_DLD  = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state                    r_state, n_state;

    logic signed [COORD_W-1:0] r_left_edge;
    logic signed [COORD_W-1:0] r_top_edge;
    logic [STEP_W-1:0]         r_step_x;
    logic [STEP_W-1:0]         r_step_y;
    logic [ITER_W-1:0]         r_max_iter;
    logic [COLOR_W-1:0]        r_color_low;
    logic [COLOR_W-1:0]        r_color_high;

    logic signed [COORD_W-1:0] r_cx, r_cy, r_zx, r_zy;
    logic [ITER_W-1:0]         r_it;
    logic                      r_inside;
    logic                      r_out_valid;
    t_pixel_out                r_out_data;

    logic                      in_accept;
    logic                      out_free;
    logic                      cfg_we;

    logic                      mul_en;
    t_mul_op                   mul_a [MUL_LANES];
    t_mul_op                   mul_b [MUL_LANES];
    t_mul_prod                 mul_p [MUL_LANES];

    t_div_req                  div_req;
    t_div_rsp                  div_rsp;
    t_div_num                  div_num  [MUL_LANES];
    t_chan                     div_quot [MUL_LANES];

    logic [PIX_W-1:0]          px, py;
    logic signed [CSUM_W-1:0]  cx_sum, cy_sum;
    logic [PROD_W-1:0]         mag;
    logic                      stop;
    logic signed [PROD_W-1:0]  xdiff, xsh, ysh;
    logic signed [COORD_W-1:0] nx, ny;

    t_chan                     lo_ch  [MUL_LANES];
    t_chan                     hi_ch  [MUL_LANES];
    t_chan                     span   [MUL_LANES];
    logic                      neg    [MUL_LANES];
    t_chan                     chan   [MUL_LANES];
    t_pixel_out                n_out;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_state != S_IDLE;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign px = i_in_data.pixel_x & PIX_X_MASK;
    assign py = i_in_data.pixel_y & PIX_Y_MASK;

    always_comb begin
        for (int k = 0; k < MUL_LANES; k++) begin
            lo_ch[k] = r_color_low[CHAN_W*(MUL_LANES-1-k) +: CHAN_W];
            hi_ch[k] = r_color_high[CHAN_W*(MUL_LANES-1-k) +: CHAN_W];
            neg[k]   = hi_ch[k] < lo_ch[k];
            span[k]  = neg[k] ? (lo_ch[k] - hi_ch[k]) : (hi_ch[k] - lo_ch[k]);
            div_num[k] = mul_p[k][DIV_NUM_W-1:0];
            chan[k]  = neg[k] ? (lo_ch[k] - div_quot[k]) : (lo_ch[k] + div_quot[k]);
        end
    end

    always_comb begin
        mul_en = 1'b0;
        for (int k = 0; k < MUL_LANES; k++) begin
            mul_a[k] = '0;
            mul_b[k] = '0;
        end
        unique case (r_state)
            S_IDLE: begin
                mul_en   = in_accept;
                mul_a[0] = $signed(COORD_W'(px));
                mul_b[0] = $signed(COORD_W'(r_step_x));
                mul_a[1] = $signed(COORD_W'(py));
                mul_b[1] = $signed(COORD_W'(r_step_y));
            end
            S_ZMUL: begin
                mul_en   = 1'b1;
                mul_a[0] = r_zx;
                mul_b[0] = r_zx;
                mul_a[1] = r_zy;
                mul_b[1] = r_zy;
                mul_a[2] = r_zx;
                mul_b[2] = r_zy;
            end
            S_RMUL: begin
                mul_en = 1'b1;
                for (int k = 0; k < MUL_LANES; k++) begin
                    mul_a[k] = $signed(COORD_W'(span[k]));
                    mul_b[k] = $signed(COORD_W'(r_it));
                end
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    mbrot_mul_unit u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign div_req.start = r_state == S_DLD;
    assign div_req.den   = r_max_iter;

    mbrot_div_unit u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_num   (div_num),
        .o_rsp   (div_rsp),
        .o_quot  (div_quot)
    );

    assign cx_sum = CSUM_W'(r_left_edge) + $signed({2'b00, mul_p[0][CPROD_W-1:0]});
    assign cy_sum = CSUM_W'(r_top_edge)  - $signed({2'b00, mul_p[1][CPROD_W-1:0]});

    assign mag   = PROD_W'(mul_p[0]) + PROD_W'(mul_p[1]);
    assign stop  = (mag > ESC_LIMIT) || (r_it >= r_max_iter);
    assign xdiff = mul_p[0] - mul_p[1];
    assign xsh   = xdiff >>> FRAC_BITS;
    assign ysh   = mul_p[2] >>> (FRAC_BITS - 1);
    assign nx    = sat32(xsh + PROD_W'(r_cx));
    assign ny    = sat32(ysh + PROD_W'(r_cy));

    always_comb begin
        n_out.iterations = r_it;
        n_out.inside_set = r_inside;
        if (r_inside) begin
            n_out.red   = '0;
            n_out.green = '0;
            n_out.blue  = '0;
        end else begin
            n_out.red   = chan[0];
            n_out.green = chan[1];
            n_out.blue  = chan[2];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_accept) n_state = S_CADD;
            S_CADD: n_state = S_ZMUL;
            S_ZMUL: n_state = S_ZUPD;
            S_ZUPD: begin
                if (!stop) begin
                    n_state = S_ZMUL;
                end else if (r_it == r_max_iter) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_RMUL;
                end
            end
            S_RMUL: n_state = S_DLD;
            S_DLD:  n_state = S_DIV;
            S_DIV:  if (div_rsp.done) n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_left_edge  <= -32'sd603979776;
            r_top_edge   <= 32'sd536870912;
            r_step_x     <= 31'd1048576;
            r_step_y     <= 31'd1048576;
            r_max_iter   <= 16'd50;
            r_color_low  <= 24'd6553600;
            r_color_high <= 24'd16776960;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_we) begin
                unique case (i_cfg_index)
                    CFG_LEFT_EDGE:  r_left_edge  <= $signed(i_cfg_data[COORD_W-1:0]);
                    CFG_TOP_EDGE:   r_top_edge   <= $signed(i_cfg_data[COORD_W-1:0]);
                    CFG_STEP_X:     r_step_x     <= i_cfg_data[STEP_W-1:0];
                    CFG_STEP_Y:     r_step_y     <= i_cfg_data[STEP_W-1:0];
                    CFG_MAX_ITER:   r_max_iter   <= i_cfg_data[ITER_W-1:0];
                    CFG_COLOR_LOW:  r_color_low  <= i_cfg_data[COLOR_W-1:0];
                    CFG_COLOR_HIGH: r_color_high <= i_cfg_data[COLOR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CADD) begin
            r_cx     <= sat32(PROD_W'(cx_sum));
            r_cy     <= sat32(PROD_W'(cy_sum));
            r_zx     <= '0;
            r_zy     <= '0;
            r_it     <= '0;
            r_inside <= 1'b0;
        end
        if (r_state == S_ZUPD) begin
            if (!stop) begin
                r_zx <= nx;
                r_zy <= ny;
                r_it <= r_it + 1'b1;
            end else begin
                r_inside <= r_it == r_max_iter;
            end
        end
        if (r_state == S_OUT && out_free) begin
            r_out_data <= n_out;
        end
    end

    a_inside_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.inside_set) |->
            (o_out_data.red == '0 && o_out_data.green == '0 && o_out_data.blue == '0
             && o_out_data.iterations == r_max_iter))
        else $error("inside point not black or count differs from limit");

    a_escaped_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.inside_set) |-> (o_out_data.iterations < r_max_iter))
        else $error("escaped point count reached the limit");

    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ZUPD) |-> (r_it <= r_max_iter))
        else $error("iteration count past the limit");

    a_div_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_rsp.busy || div_rsp.done) |-> (r_state == S_DIV))
        else $error("divider active outside the divide phase");

endmodule

// ===== test/mandelbrot_escape_time_pixel_checker.sv =====
// Checker for the Mandelbrot pixel core: mirrors the registers, predicts every pixel, compares results.
module mandelbrot_escape_time_pixel_checker
    import mbrot_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_pixel_in             i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_pixel_out            i_out_data,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ESC_SH = 2 * FRAC_BITS + 2;
    localparam longint unsigned ESCAPE_MAG =
        (ESC_SH > 63) ? 64'hFFFF_FFFF_FFFF_FFFF : (64'd1 << ESC_SH);

    logic signed [COORD_W-1:0] left_edge;
    logic signed [COORD_W-1:0] top_edge;
    logic [STEP_W-1:0]         step_x;
    logic [STEP_W-1:0]         step_y;
    logic [ITER_W-1:0]         iter_limit;
    logic [COLOR_W-1:0]        ramp_low;
    logic [COLOR_W-1:0]        ramp_high;

    t_pixel_out expected_pixels[$];

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic t_chan ramp_channel(t_chan lo, t_chan hi, longint count, longint limit);
        longint v;
        v = longint'(lo) + ((longint'(hi) - longint'(lo)) * count) / limit;
        return v[CHAN_W-1:0];
    endfunction

    function automatic t_pixel_out escape_time_pixel(t_pixel_in px);
        longint col;
        longint row;
        longint cre;
        longint cim;
        longint zre;
        longint zim;
        longint sq_re;
        longint sq_im;
        longint nre;
        longint count;
        longint limit;
        longint unsigned mag;
        t_pixel_out res;
        col = longint'(px.pixel_x % MAX_WIDTH);
        row = longint'(px.pixel_y % MAX_HEIGHT);
        cre = clamp32(longint'(left_edge) + col * longint'(step_x));
        cim = clamp32(longint'(top_edge) - row * longint'(step_y));
        limit = longint'(iter_limit);
        zre = 0;
        zim = 0;
        count = 0;
        while (count < limit) begin
            sq_re = zre * zre;
            sq_im = zim * zim;
            mag = sq_re + sq_im;
            if (mag > ESCAPE_MAG) begin
                break;
            end
            nre = clamp32(((sq_re - sq_im) >>> FRAC_BITS) + cre);
            zim = clamp32(((zre * zim) >>> (FRAC_BITS - 1)) + cim);
            zre = nre;
            count++;
        end
        res.iterations = count[ITER_W-1:0];
        res.inside_set = (count == limit);
        if (res.inside_set) begin
            res.red   = '0;
            res.green = '0;
            res.blue  = '0;
        end else begin
            res.red   = ramp_channel(ramp_low[23:16], ramp_high[23:16], count, limit);
            res.green = ramp_channel(ramp_low[15:8], ramp_high[15:8], count, limit);
            res.blue  = ramp_channel(ramp_low[7:0], ramp_high[7:0], count, limit);
        end
        return res;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("pixel result %s: expected %0d, got %0d", name, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel_out want;
        if (!i_rst_n) begin
            left_edge = 32'shDC00_0000;
            top_edge = 32'sh2000_0000;
            step_x = 31'h0010_0000;
            step_y = 31'h0010_0000;
            iter_limit = 16'd50;
            ramp_low = 24'h64_0000;
            ramp_high = 24'hFF_FF00;
            expected_pixels.delete();
            o_mismatches = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LEFT_EDGE: begin
                        left_edge = i_cfg_data;
                    end
                    CFG_TOP_EDGE: begin
                        top_edge = i_cfg_data;
                    end
                    CFG_STEP_X: begin
                        step_x = i_cfg_data[STEP_W-1:0];
                    end
                    CFG_STEP_Y: begin
                        step_y = i_cfg_data[STEP_W-1:0];
                    end
                    CFG_MAX_ITER: begin
                        iter_limit = i_cfg_data[ITER_W-1:0];
                    end
                    CFG_COLOR_LOW: begin
                        ramp_low = i_cfg_data[COLOR_W-1:0];
                    end
                    CFG_COLOR_HIGH: begin
                        ramp_high = i_cfg_data[COLOR_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_pixels.size() == 0) begin
                    $error("pixel result transaction with no pixel outstanding");
                    o_mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("red", want.red, i_out_data.red);
                    check_field("green", want.green, i_out_data.green);
                    check_field("blue", want.blue, i_out_data.blue);
                    check_field("iterations", want.iterations, i_out_data.iterations);
                    check_field("inside_set", want.inside_set, i_out_data.inside_set);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_pixels.push_back(escape_time_pixel(i_in_data));
            end
        end
        o_pending = expected_pixels.size();
    end

endmodule

// ===== test/tb_mandelbrot_escape_time_pixel_core.sv =====
// Testbench top for the Mandelbrot pixel core: drives pixels, register writes and output stalls.
module tb_mandelbrot_escape_time_pixel_core
    import mbrot_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 400000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 123;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_pixel_in             in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_pixel_out            out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    mismatches;
    int                    pending;
    int                    idle_cycles = 0;
    bit                    quiet = 1'b0;
    bit                    hold_request = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    mandelbrot_escape_time_pixel_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    mandelbrot_escape_time_pixel_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    function automatic int draw_gap();
        return quiet ? 0 : int'($urandom_range(0, 6));
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
        int gap;
        gap = draw_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{pixel_x: x, pixel_y: y};
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        int hold;
        forever begin
            if (hold_request) begin
                hold = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                hold = draw_gap();
            end
            if (hold != 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_mandelbrot_escape_time_pixel_core NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned span;
        logic [CFG_DATA_W-1:0] step;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default view: corners, bit patterns, origin, c = -0.75
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);
        send_pixel(12'd576, 12'd512);
        send_pixel(12'd384, 12'd512);
        send_pixel(12'hFFF, 12'd0);
        wait_idle();

        write_reg(CFG_MAX_ITER, 32'd0);
        send_pixel(12'd576, 12'd512);
        send_pixel(12'd0, 12'd0);
        wait_idle();

        write_reg(CFG_MAX_ITER, 32'd1);
        send_pixel(12'd576, 12'd512);
        send_pixel(12'd100, 12'd300);
        wait_idle();

        // falling ramp
        write_reg(CFG_MAX_ITER, 32'd7);
        write_reg(CFG_COLOR_LOW, 32'h00FF_FFFF);
        write_reg(CFG_COLOR_HIGH, 32'h0000_0000);
        send_pixel(12'd300, 12'd512);
        send_pixel(12'd450, 12'd600);
        send_pixel(12'd0, 12'd512);
        wait_idle();

        // saturate c both ways
        write_reg(CFG_LEFT_EDGE, 32'h7FFF_FFFF);
        write_reg(CFG_TOP_EDGE, 32'h8000_0000);
        write_reg(CFG_STEP_X, 32'hFFFF_FFFF);
        write_reg(CFG_STEP_Y, 32'hFFFF_FFFF);
        write_reg(CFG_UNMAPPED, 32'hFFFF_FFFF);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd1);
        wait_idle();

        write_reg(CFG_LEFT_EDGE, 32'h8000_0000);
        write_reg(CFG_TOP_EDGE, 32'h7FFF_FFFF);
        write_reg(CFG_STEP_X, 32'd0);
        write_reg(CFG_STEP_Y, 32'd0);
        send_pixel(12'hFFF, 12'hFFF);
        wait_idle();

        // longest limit: origin stays inside, c = 3 escapes after its first iteration
        write_reg(CFG_LEFT_EDGE, 32'd0);
        write_reg(CFG_TOP_EDGE, 32'd0);
        write_reg(CFG_STEP_X, 32'd1 << FRAC_BITS);
        write_reg(CFG_MAX_ITER, 32'hFFFF);
        write_reg(CFG_COLOR_LOW, 32'h0012_3456);
        write_reg(CFG_COLOR_HIGH, 32'h00FE_DCBA);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd3, 12'd0);
        wait_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            quiet = (phase % 4 == 1);
            hold_request = (phase == 2);
            if (phase % 3 == 2) begin
                span = 4096;
                write_reg(CFG_LEFT_EDGE, $urandom());
                write_reg(CFG_TOP_EDGE, $urandom());
                write_reg(CFG_STEP_X, $urandom());
                write_reg(CFG_STEP_Y, $urandom());
            end else begin
                span = $urandom_range(16, 256);
                step = (32'd3 << FRAC_BITS) / span;
                write_reg(CFG_LEFT_EDGE, 32'hDC00_0000 + $urandom_range(0, 32'h0800_0000));
                write_reg(CFG_TOP_EDGE, 32'h1800_0000 - $urandom_range(0, 32'h0400_0000));
                write_reg(CFG_STEP_X, step);
                write_reg(CFG_STEP_Y, step + $urandom_range(0, step / 8));
            end
            write_reg(CFG_MAX_ITER, $urandom_range(1, (phase == 5) ? 400 : 64));
            write_reg(CFG_COLOR_LOW, $urandom());
            write_reg(CFG_COLOR_HIGH, $urandom());
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_pixel(PIX_W'($urandom_range(0, 4095)),
                               PIX_W'($urandom_range(0, 4095)));
                end else begin
                    send_pixel(PIX_W'($urandom_range(0, span - 1)),
                               PIX_W'($urandom_range(0, span - 1)));
                end
            end
            wait_idle();
        end

        if (mismatches == 0 && pending == 0) begin
            $display("tb_mandelbrot_escape_time_pixel_core OK");
        end else begin
            $display("tb_mandelbrot_escape_time_pixel_core NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mbrot_pkg.sv
src/mbrot_mul_unit.sv
src/mbrot_div_unit.sv
src/mandelbrot_escape_time_pixel_core.sv
test/mandelbrot_escape_time_pixel_checker.sv
test/tb_mandelbrot_escape_time_pixel_core.sv
